// File: sv/sscrg_pkg.sv
// Shared types, constants and helpers for the seven-segment clock rectangle generator.
// No dependencies; every other file of the block imports this package.
package sscrg_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int HOUR_W    = 5;
  localparam int MINUTE_W  = 6;
  localparam int NUDGE_W   = 16;
  localparam int COORD_W   = 16;
  localparam int SEG_N     = 7;
  localparam int DIGIT_N   = 4;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Layout pipeline depth from a register write to a settled layout.
  localparam int LAYOUT_LAT   = 5;
  localparam int LAYOUT_CNT_W = $clog2(LAYOUT_LAT + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_X,
    REG_SCREEN_Y,
    REG_SCREEN_W,
    REG_SCREEN_H
  } cfg_reg_t;

  // Segment slots in draw order.
  typedef enum logic [2:0] {
    SL_TOP,
    SL_BOT,
    SL_MID,
    SL_UL,
    SL_UR,
    SL_LL,
    SL_LR
  } seg_slot_t;

  typedef logic [SEG_N-1:0] seg_mask_t;

  localparam seg_mask_t MASK_MID = 7'b0000100;

  // Classic abcdefg glyphs: bit0 top, bit1 upper right, bit2 lower right,
  // bit3 bottom, bit4 lower left, bit5 upper left, bit6 middle.
  localparam logic [6:0] GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // Glyph for a digit, reordered into draw order.
  function automatic seg_mask_t glyph_mask(input logic [3:0] d);
    logic [6:0] g;
    seg_mask_t  m;
    g = (d < 4'd10) ? GLYPH[d] : 7'h00;
    m[SL_TOP] = g[0];
    m[SL_BOT] = g[3];
    m[SL_MID] = g[6];
    m[SL_UL]  = g[5];
    m[SL_UR]  = g[1];
    m[SL_LL]  = g[4];
    m[SL_LR]  = g[2];
    return m;
  endfunction

  typedef struct packed {
    seg_mask_t [DIGIT_N-1:0] seg;
    logic signed [2:0]       dx;
    logic signed [2:0]       dy;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0]           sx;
    logic [CFG_W-1:0]           sy;
    logic [CFG_W-1:0]           sw;
    logic [CFG_W-1:0]           sh;
    logic signed [COORD_W-1:0]  base_x;
    logic signed [COORD_W-1:0]  base_y;
    logic                       step4x;
    logic                       step4y;
    logic signed [COORD_W-1:0]  t;
    logic signed [COORD_W-1:0]  xo_r;
    logic signed [COORD_W-1:0]  xo_col;
    logic signed [COORD_W-1:0]  yo_bot;
    logic signed [COORD_W-1:0]  yo_mid;
    logic signed [COORD_W-1:0]  yo_lo;
    logic signed [COORD_W-1:0]  yo_c1;
    logic signed [COORD_W-1:0]  yo_c2;
    logic signed [COORD_W-1:0]  wseg;
    logic signed [COORD_W-1:0]  vh;
    logic signed [COORD_W-1:0]  pitch;
    logic signed [COORD_W-1:0]  cadj;
  } layout_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BG,
    ST_DIGIT,
    ST_COLON
  } back_state_t;

endpackage

// File: sv/seven_segment_clock_rect_generator.sv
// An update reaches the output via the front register, queue and state register.
// Draw rate is one slot per cycle, lit slots waiting out output stalls; unlit slots
// are walked too, up to 31 per update (background, 28 segments, 2 colon squares).
// A two-entry queue lets the next update be taken while the current one is drawn.
// Layout settles again after reset or a register write once its pipeline refills.
// Reset: synchronous, active high; registers return to 0, 0, 320, 240.
module seven_segment_clock_rect_generator #(
  parameter int QUEUE_DEPTH = sscrg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sscrg_pkg::HOUR_W-1:0]         hour,
  input  logic [sscrg_pkg::MINUTE_W-1:0]       minute,
  input  logic                                 time_valid,
  input  logic [sscrg_pkg::NUDGE_W-1:0]        nudge,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_left,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_top,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_width,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_height,
  output logic                                 colour,
  output logic                                 last_rect,
  input  logic                                 cfg_write,
  input  logic [sscrg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sscrg_pkg::CFG_W-1:0]          cfg_data
);
  import sscrg_pkg::*;

  logic    wr_valid;
  logic    wr_stall;
  item_t   wr_item;
  logic    rd_valid;
  logic    rd_take;
  item_t   rd_item;
  layout_t lay;
  logic    lay_ready;

  sscrg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hour       (hour),
    .minute     (minute),
    .time_valid (time_valid),
    .nudge      (nudge),
    .wr_valid   (wr_valid),
    .wr_stall   (wr_stall),
    .wr_item    (wr_item)
  );

  sscrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr_item  (wr_item),
    .rd_valid (rd_valid),
    .rd_take  (rd_take),
    .rd_item  (rd_item)
  );

  sscrg_layout u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lay       (lay),
    .lay_ready (lay_ready)
  );

  sscrg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rd_valid    (rd_valid),
    .rd_take     (rd_take),
    .rd_item     (rd_item),
    .lay         (lay),
    .lay_ready   (lay_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .colour      (colour),
    .last_rect   (last_rect)
  );

endmodule

// File: sv/sscrg_front.sv
// Input stage: accepts an update, splits the time into digit segment masks
// and reduces the nudge counter mod 25. Depends on sscrg_pkg.
module sscrg_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [sscrg_pkg::HOUR_W-1:0]   hour,
  input  logic [sscrg_pkg::MINUTE_W-1:0] minute,
  input  logic                           time_valid,
  input  logic [sscrg_pkg::NUDGE_W-1:0]  nudge,
  output logic                           wr_valid,
  input  logic                           wr_stall,
  output sscrg_pkg::item_t               wr_item
);
  import sscrg_pkg::*;

  logic                    f_valid;
  seg_mask_t [DIGIT_N-1:0] f_seg;
  logic [10:0]             f_sum;
  logic [6:0]              f_quo;

  logic [1:0]              h_tens;
  logic [3:0]              h_units;
  logic [2:0]              m_tens;
  logic [3:0]              m_units;
  seg_mask_t [DIGIT_N-1:0] seg_in;
  logic [10:0]             nsum;
  logic [21:0]             nprod;
  logic                    take;
  logic [4:0]              m25;
  logic [2:0]              row;
  logic [4:0]              col;

  assign in_stall = f_valid && wr_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    priority if (hour >= 5'd30) h_tens = 2'd3;
    else if (hour >= 5'd20)     h_tens = 2'd2;
    else if (hour >= 5'd10)     h_tens = 2'd1;
    else                        h_tens = 2'd0;
    h_units = 4'(hour - 5'(10 * h_tens));

    priority if (minute >= 6'd60) m_tens = 3'd6;
    else if (minute >= 6'd50)     m_tens = 3'd5;
    else if (minute >= 6'd40)     m_tens = 3'd4;
    else if (minute >= 6'd30)     m_tens = 3'd3;
    else if (minute >= 6'd20)     m_tens = 3'd2;
    else if (minute >= 6'd10)     m_tens = 3'd1;
    else                          m_tens = 3'd0;
    m_units = 4'(minute - 6'(10 * m_tens));

    if (time_valid) begin
      seg_in[0] = (h_tens == 2'd0) ? '0 : glyph_mask(4'(h_tens));
      seg_in[1] = glyph_mask(h_units);
      seg_in[2] = glyph_mask(4'(m_tens));
      seg_in[3] = glyph_mask(m_units);
    end else begin
      seg_in = {DIGIT_N{MASK_MID}};
    end
  end

  // 256 = 6 mod 25, so fold the high byte before the reciprocal divide.
  assign nsum  = 11'(nudge[15:8]) * 11'd6 + 11'(nudge[7:0]);
  assign nprod = 22'(nsum) * 22'd1311;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (!wr_stall) begin
      f_valid <= 1'b0;
    end
    if (take) begin
      f_seg <= seg_in;
      f_sum <= nsum;
      f_quo <= nprod[21:15];
    end
  end

  always_comb begin
    m25 = 5'(f_sum - 11'(f_quo) * 11'd25);
    priority if (m25 >= 5'd20) row = 3'd4;
    else if (m25 >= 5'd15)     row = 3'd3;
    else if (m25 >= 5'd10)     row = 3'd2;
    else if (m25 >= 5'd5)      row = 3'd1;
    else                       row = 3'd0;
    col = 5'(m25 - 5'(5 * row));
  end

  assign wr_valid    = f_valid;
  assign wr_item.seg = f_seg;
  assign wr_item.dx  = 3'(col) - 3'd2;
  assign wr_item.dy  = row - 3'd2;

endmodule

// File: sv/sscrg_queue.sv
// Short FIFO of classified updates between the front and back stages.
// Depends on sscrg_pkg for the entry type.
module sscrg_queue #(
  parameter int DEPTH = sscrg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  sscrg_pkg::item_t wr_item,
  output logic             rd_valid,
  input  logic             rd_take,
  output sscrg_pkg::item_t rd_item
);
  import sscrg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_stall = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: sv/sscrg_layout.sv
// Screen registers and the pipelined clock layout derived from them.
// Depends on sscrg_pkg; layout is flagged ready once the pipeline has settled.
module sscrg_layout (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [sscrg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sscrg_pkg::CFG_W-1:0]     cfg_data,
  output sscrg_pkg::layout_t              lay,
  output logic                            lay_ready
);
  import sscrg_pkg::*;

  logic [CFG_W-1:0]        sx, sy, sw, sh;
  logic [LAYOUT_CNT_W-1:0] settle;

  // stage A
  logic [23:0]             q9_prod;
  logic [8:0]              q9;
  logic [8:0]              w1;
  logic [10:0]             shh1;
  // stage B
  logic [9:0]              w2x;
  logic [16:0]             t_prod;
  logic [6:0]              t_q;
  logic [18:0]             g_prod;
  logic [8:0]              w2;
  logic [9:0]              h2;
  logic [6:0]              t2;
  logic [7:0]              gap2;
  logic [7:0]              colon2;
  // stage C
  logic [19:0]             h3_prod;
  logic signed [11:0]      hmt;
  logic signed [11:0]      hmt_adj;
  logic [12:0]             total3;
  logic [8:0]              h3_3;
  logic signed [11:0]      mid3;
  // stage D
  logic signed [13:0]      dsx;
  logic signed [13:0]      dsx_adj;
  logic [COORD_W-1:0]      mid16;
  logic signed [13:0]      slack_x4;
  logic [10:0]             slack_y4;
  // stage D/E outputs
  logic signed [COORD_W-1:0] base_x, base_y;
  logic                      step4x, step4y;
  logic signed [COORD_W-1:0] t_r, xo_r, xo_col, yo_bot, yo_mid, yo_lo;
  logic signed [COORD_W-1:0] yo_c1, yo_c2, wseg, vh, pitch, cadj;

  always_ff @(posedge clk) begin
    if (rst) begin
      sx     <= 12'd0;
      sy     <= 12'd0;
      sw     <= 12'd320;
      sh     <= 12'd240;
      settle <= LAYOUT_CNT_W'(LAYOUT_LAT);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_X: sx <= cfg_data;
        REG_SCREEN_Y: sy <= cfg_data;
        REG_SCREEN_W: sw <= cfg_data;
        REG_SCREEN_H: sh <= cfg_data;
        default: ;
      endcase
      settle <= LAYOUT_CNT_W'(LAYOUT_LAT);
    end else if (settle != '0) begin
      settle <= settle - 1'b1;
    end
  end

  assign lay_ready = (settle == '0);

  // width / 9 by reciprocal, exact for 12-bit values
  assign q9_prod = 24'(sw) * 24'd3641;
  assign q9      = q9_prod[23:15];

  assign w2x    = {w1, 1'b0};
  assign t_prod = 17'(w1) * 17'd205;
  assign t_q    = t_prod[16:10];
  assign g_prod = 19'(w1) * 19'd683;

  assign h3_prod = 20'(h2) * 20'd683;
  assign hmt     = $signed({2'b00, h2}) - $signed({5'b00000, t2});
  assign hmt_adj = hmt + $signed({11'b0, hmt[11]});

  assign dsx     = $signed({2'b00, sw}) - $signed({1'b0, total3});
  assign dsx_adj = dsx + $signed({13'b0, dsx[13]});
  assign mid16   = {{(COORD_W-12){mid3[11]}}, mid3};

  always_ff @(posedge clk) begin
    // stage A
    w1   <= (q9 < 9'd6) ? 9'd6 : q9;
    shh1 <= sh[11:1];
    // stage B
    w2     <= w1;
    h2     <= (11'(w2x) < shh1) ? w2x : 10'(shh1);
    t2     <= (t_q < 7'd2) ? 7'd2 : t_q;
    gap2   <= g_prod[18:11];
    colon2 <= w1[8:1];
    // stage C
    total3 <= 13'({w2, 2'b00}) + 13'(gap2) * 13'd3 + 13'(colon2);
    h3_3   <= h3_prod[19:11];
    mid3   <= hmt_adj >>> 1;
    // stage D
    slack_x4 <= dsx_adj >>> 1;
    slack_y4 <= 11'((sh - 12'(h2)) >> 1);
    t_r      <= 16'(t2);
    xo_r     <= 16'(w2) - 16'(t2);
    xo_col   <= 16'd0 - 16'(gap2[7:1]) - 16'(t2[6:1]);
    yo_bot   <= 16'(h2) - 16'(t2);
    yo_mid   <= mid16;
    yo_lo    <= mid16 + 16'(t2);
    yo_c1    <= 16'(h3_3);
    yo_c2    <= 16'(h2) - 16'(h3_3) - 16'(t2);
    wseg     <= 16'(w2) - 16'({t2, 1'b0});
    vh       <= mid16 - 16'(t2);
    pitch    <= 16'(w2) + 16'(gap2);
    cadj     <= 16'(colon2) - 16'(gap2);
    // stage E
    base_x <= 16'(sx) + {{(COORD_W-14){slack_x4[13]}}, slack_x4};
    base_y <= 16'(sy) + 16'(slack_y4);
    step4x <= (slack_x4 > 14'sd8);
    step4y <= (slack_y4 > 11'd8);
  end

  always_comb begin
    lay.sx     = sx;
    lay.sy     = sy;
    lay.sw     = sw;
    lay.sh     = sh;
    lay.base_x = base_x;
    lay.base_y = base_y;
    lay.step4x = step4x;
    lay.step4y = step4y;
    lay.t      = t_r;
    lay.xo_r   = xo_r;
    lay.xo_col = xo_col;
    lay.yo_bot = yo_bot;
    lay.yo_mid = yo_mid;
    lay.yo_lo  = yo_lo;
    lay.yo_c1  = yo_c1;
    lay.yo_c2  = yo_c2;
    lay.wseg   = wseg;
    lay.vh     = vh;
    lay.pitch  = pitch;
    lay.cadj   = cadj;
  end

endmodule

// File: sv/sscrg_back.sv
// Rectangle sequencer: walks background, digit segments and colon of one update,
// one slot per cycle bar stalled lit slots, into a registered output; uses sscrg_pkg.
module sscrg_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_valid,
  output logic                                rd_take,
  input  sscrg_pkg::item_t                    rd_item,
  input  sscrg_pkg::layout_t                  lay,
  input  logic                                lay_ready,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_left,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_top,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_width,
  output logic signed [sscrg_pkg::COORD_W-1:0] rect_height,
  output logic                                colour,
  output logic                                last_rect
);
  import sscrg_pkg::*;

  back_state_t             state, state_next;
  seg_mask_t [DIGIT_N-1:0] item_seg;
  logic [COORD_W-1:0]      x_dig;
  logic [COORD_W-1:0]      y_it;
  logic [1:0]              dig;
  seg_slot_t               seg;
  logic                    cidx;

  logic                    out_free;
  logic                    lit;
  logic                    last;
  logic                    go;
  logic                    finish;
  logic                    pop;
  seg_mask_t               cur_mask;
  seg_mask_t               hi_bits;
  logic                    later_empty;
  logic [COORD_W-1:0]      bx, by, xo, yo, rw, rh;
  logic                    col_c;
  logic [COORD_W-1:0]      dxs, dys;

  assign out_free = !out_valid || !out_stall;
  assign cur_mask = item_seg[dig];
  assign hi_bits  = cur_mask >> seg;

  always_comb begin
    unique case (dig)
      2'd2:    later_empty = (item_seg[3] == '0);
      2'd3:    later_empty = 1'b1;
      default: later_empty = 1'b0;
    endcase
  end

  // slot outputs
  always_comb begin
    lit   = 1'b0;
    last  = 1'b0;
    col_c = 1'b1;
    bx    = x_dig;
    by    = y_it;
    xo    = '0;
    yo    = '0;
    rw    = lay.t;
    rh    = lay.t;
    unique case (state)
      ST_IDLE: ;
      ST_BG: begin
        lit   = 1'b1;
        col_c = 1'b0;
        bx    = 16'(lay.sx);
        by    = 16'(lay.sy);
        rw    = 16'(lay.sw);
        rh    = 16'(lay.sh);
      end
      ST_DIGIT: begin
        lit  = hi_bits[0];
        last = (hi_bits[6:1] == '0) && later_empty;
        unique case (seg)
          SL_TOP: begin xo = lay.t;    yo = '0;         rw = lay.wseg; end
          SL_BOT: begin xo = lay.t;    yo = lay.yo_bot; rw = lay.wseg; end
          SL_MID: begin xo = lay.t;    yo = lay.yo_mid; rw = lay.wseg; end
          SL_UL:  begin xo = '0;       yo = lay.t;      rh = lay.vh;   end
          SL_UR:  begin xo = lay.xo_r; yo = lay.t;      rh = lay.vh;   end
          SL_LL:  begin xo = '0;       yo = lay.yo_lo;  rh = lay.vh;   end
          SL_LR:  begin xo = lay.xo_r; yo = lay.yo_lo;  rh = lay.vh;   end
          default: lit = 1'b0;
        endcase
      end
      ST_COLON: begin
        lit  = 1'b1;
        last = cidx && (item_seg[2] == '0) && (item_seg[3] == '0);
        xo   = lay.xo_col;
        yo   = cidx ? lay.yo_c2 : lay.yo_c1;
      end
      default: ;
    endcase
    go     = (state != ST_IDLE) && (!lit || out_free);
    finish = go && lit && last;
    pop    = ((state == ST_IDLE) || finish) && rd_valid && lay_ready;
  end

  assign rd_take = pop;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (pop) state_next = ST_BG;
      ST_BG:   if (go) state_next = ST_DIGIT;
      ST_DIGIT: begin
        if (finish) begin
          state_next = pop ? ST_BG : ST_IDLE;
        end else if (go && seg == SL_LR) begin
          if (dig == 2'd1) begin
            state_next = ST_COLON;
          end else if (dig == 2'd3) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_COLON: begin
        if (finish) begin
          state_next = pop ? ST_BG : ST_IDLE;
        end else if (go && cidx) begin
          state_next = ST_DIGIT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // nudge offset: dx or 4*dx
  assign dxs = lay.step4x ? {{(COORD_W-3){rd_item.dx[2]}}, rd_item.dx} << 2
                          : {{(COORD_W-3){rd_item.dx[2]}}, rd_item.dx};
  assign dys = lay.step4y ? {{(COORD_W-3){rd_item.dy[2]}}, rd_item.dy} << 2
                          : {{(COORD_W-3){rd_item.dy[2]}}, rd_item.dy};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (go && lit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (go && lit) begin
      rect_left   <= bx + xo;
      rect_top    <= by + yo;
      rect_width  <= rw;
      rect_height <= rh;
      colour      <= col_c;
      last_rect   <= last;
    end

    if (state == ST_BG && go) begin
      dig  <= 2'd0;
      seg  <= SL_TOP;
      cidx <= 1'b0;
    end else if (state == ST_DIGIT && go) begin
      if (seg == SL_LR) begin
        seg <= SL_TOP;
        dig <= dig + 1'b1;
      end else begin
        seg <= seg_slot_t'(seg + 1'b1);
      end
    end else if (state == ST_COLON && go) begin
      cidx <= ~cidx;
    end

    // a new update takes over the digit origin on the cycle the last one finishes
    if (pop) begin
      item_seg <= rd_item.seg;
      x_dig    <= lay.base_x + dxs;
      y_it     <= lay.base_y + dys;
    end else if (state == ST_DIGIT && go && seg == SL_LR) begin
      x_dig <= x_dig + lay.pitch;
    end else if (state == ST_COLON && go && cidx) begin
      x_dig <= x_dig + lay.cadj;
    end
  end

endmodule

// File: tb/tb_seven_segment_clock_rect_generator.sv
// Self-checking testbench for the seven-segment clock rectangle generator.
// Depends on sscrg_pkg and seven_segment_clock_rect_generator; drives a directed table, then
// random updates over several screen settings, and checks every rectangle against a predictor.
module tb_seven_segment_clock_rect_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import sscrg_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT        = 200;   // updates accepted before the long output hold
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = LAYOUT_LAT + 4;
  localparam int TAIL_CYCLES    = 40;    // quiet gap after the output has drained
  localparam int PHASE_ITEMS    = 52;
  localparam int NO_COUNT       = -1;

  // Segment bits of a glyph byte.
  localparam logic [6:0] SEG_TOP = 7'h01;
  localparam logic [6:0] SEG_UR  = 7'h02;
  localparam logic [6:0] SEG_LR  = 7'h04;
  localparam logic [6:0] SEG_BOT = 7'h08;
  localparam logic [6:0] SEG_LL  = 7'h10;
  localparam logic [6:0] SEG_UL  = 7'h20;
  localparam logic [6:0] SEG_MID = 7'h40;
  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  typedef struct {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic        colour;
    logic        last;
  } rect_t;

  typedef struct packed {
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic        tv;
    logic [15:0] ng;
    int          count;   // rectangles expected, NO_COUNT where not typed
  } update_row_t;

  localparam update_row_t DIRECTED [17] = '{
    '{5'd0,  6'd0,  1'b1, 16'd0,     21},  // leading zero hour skipped
    '{5'd0,  6'd0,  1'b0, 16'd0,     7},   // invalid time: middle bars only
    '{5'd23, 6'd59, 1'b1, 16'd12,    24},
    '{5'd31, 6'd63, 1'b1, 16'd65535, 21},  // out-of-range hour and minute
    '{5'd31, 6'd63, 1'b0, 16'd65535, 7},
    '{5'd12, 6'd34, 1'b1, 16'd24,    NO_COUNT},
    '{5'd9,  6'd58, 1'b1, 16'd5,     NO_COUNT},
    '{5'd16, 6'd7,  1'b1, 16'd1,     NO_COUNT},
    '{5'd28, 6'd8,  1'b1, 16'd20,    NO_COUNT},
    '{5'd10, 6'd10, 1'b1, 16'd6,     NO_COUNT},
    '{5'd20, 6'd0,  1'b1, 16'd7,     NO_COUNT},
    '{5'd1,  6'd11, 1'b1, 16'd65534, NO_COUNT},
    '{5'd7,  6'd47, 1'b0, 16'd3,     7},
    '{5'd19, 6'd29, 1'b1, 16'd18,    NO_COUNT},
    '{5'd0,  6'd1,  1'b1, 16'd0,     NO_COUNT},
    '{5'd15, 6'd55, 1'b1, 16'd43690, NO_COUNT},
    '{5'd21, 6'd30, 1'b1, 16'd21845, NO_COUNT}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic                time_valid;
  logic [NUDGE_W-1:0]  nudge;
  logic                out_valid;
  logic                out_stall;
  logic signed [COORD_W-1:0] rect_left;
  logic signed [COORD_W-1:0] rect_top;
  logic signed [COORD_W-1:0] rect_width;
  logic signed [COORD_W-1:0] rect_height;
  logic                colour;
  logic                last_rect;
  logic                cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  // screen registers as the testbench has written them
  int    scr_x, scr_y, scr_w, scr_h;
  rect_t pending_rects [$];
  int    typed_counts [$];
  int    errors;
  int    rects_seen;
  int    rects_in_update;
  int    n_updates;
  int    idle_cycles;
  logic  calm;

  seven_segment_clock_rect_generator dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .hour        (hour),
    .minute      (minute),
    .time_valid  (time_valid),
    .nudge       (nudge),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .colour      (colour),
    .last_rect   (last_rect),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_rect(input int l, input int tp, input int wd, input int ht,
                                   input logic col);
    rect_t r;
    r.left   = l[15:0];
    r.top    = tp[15:0];
    r.wid    = wd[15:0];
    r.hgt    = ht[15:0];
    r.colour = col;
    r.last   = 1'b0;
    pending_rects.push_back(r);
  endfunction

  // Queues every rectangle one update draws, in output order.
  function automatic void draw_clock(input logic [4:0] hr, input logic [5:0] mn,
                                     input logic tv, input logic [15:0] ng);
    int         w, h, t, gap, colon_w, total, slack_x, slack_y, dx, dy, step_x, step_y;
    int         x, y, cx, mid, vh;
    int         dig [4];
    logic [6:0] segs;
    rect_t      r;
    add_rect(scr_x, scr_y, scr_w, scr_h, 1'b0);
    w = scr_w / 9;
    if (w < 6) w = 6;
    h = 2 * w;
    if (h > scr_h / 2) h = scr_h / 2;
    t = w / 5;
    if (t < 2) t = 2;
    gap = w / 3;
    colon_w = w / 2;
    total = 4 * w + 3 * gap + colon_w;
    slack_x = (scr_w - total) / 2;
    slack_y = (scr_h - h) / 2;
    dx = int'(ng) % 5 - 2;
    dy = (int'(ng) / 5) % 5 - 2;
    step_x = (slack_x > 8) ? 4 : 1;
    step_y = (slack_y > 8) ? 4 : 1;
    x = scr_x + slack_x + dx * step_x;
    y = scr_y + slack_y + dy * step_y;
    dig[0] = int'(hr) / 10;
    dig[1] = int'(hr) % 10;
    dig[2] = int'(mn) / 10;
    dig[3] = int'(mn) % 10;
    mid = y + (h - t) / 2;
    vh = mid - y - t;
    for (int i = 0; i < 4; i++) begin
      if (!tv) segs = SEG_MID;
      else if (i == 0 && dig[0] == 0) segs = '0;   // leading zero hour digit
      else segs = DIGIT_SEGS[dig[i]];
      if (segs & SEG_TOP) add_rect(x + t, y, w - 2 * t, t, 1'b1);
      if (segs & SEG_BOT) add_rect(x + t, y + h - t, w - 2 * t, t, 1'b1);
      if (segs & SEG_MID) add_rect(x + t, mid, w - 2 * t, t, 1'b1);
      if (segs & SEG_UL)  add_rect(x, y + t, t, vh, 1'b1);
      if (segs & SEG_UR)  add_rect(x + w - t, y + t, t, vh, 1'b1);
      if (segs & SEG_LL)  add_rect(x, mid + t, t, vh, 1'b1);
      if (segs & SEG_LR)  add_rect(x + w - t, mid + t, t, vh, 1'b1);
      x += w + gap;
      if (i == 1) begin
        cx = x - gap / 2 - t / 2;
        add_rect(cx, y + h / 3, t, t, 1'b1);
        add_rect(cx, y + h - h / 3 - t, t, t, 1'b1);
        x += colon_w - gap;
      end
    end
    r = pending_rects.pop_back();
    r.last = 1'b1;
    pending_rects.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("%0t ns: rect %0d %s: got %0h, expected %0h", $time, rects_seen, what, got,
             want);
  endtask

  task automatic send_update(input logic [4:0] hr, input logic [5:0] mn, input logic tv,
                             input logic [15:0] ng, input int count);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    hour       <= hr;
    minute     <= mn;
    time_valid <= tv;
    nudge      <= ng;
    do @(posedge clk); while (in_stall);
    draw_clock(hr, mn, tv, ng);
    typed_counts.push_back(count);
  endtask

  // Sender goes quiet until every queued rectangle has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rects.size() != 0);
  endtask

  task automatic set_screen(input logic [11:0] x, input logic [11:0] y,
                            input logic [11:0] wd, input logic [11:0] ht);
    cfg_write <= 1'b1;
    cfg_index <= REG_SCREEN_X;
    cfg_data  <= x;
    @(posedge clk);
    cfg_index <= REG_SCREEN_Y;
    cfg_data  <= y;
    @(posedge clk);
    cfg_index <= REG_SCREEN_W;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= REG_SCREEN_H;
    cfg_data  <= ht;
    @(posedge clk);
    cfg_write <= 1'b0;
    scr_x = int'(x);
    scr_y = int'(y);
    scr_w = int'(wd);
    scr_h = int'(ht);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // output checker
  always @(posedge clk) begin : rect_check
    rect_t want;
    int    typed;
    if (!rst && out_valid && !out_stall) begin
      rects_seen++;
      rects_in_update++;
      if (pending_rects.size() == 0) begin
        report_mismatch("rectangle with nothing expected", rect_left, '0);
      end else begin
        want = pending_rects.pop_front();
        if (rect_left !== want.left)    report_mismatch("rect_left", rect_left, want.left);
        if (rect_top !== want.top)      report_mismatch("rect_top", rect_top, want.top);
        if (rect_width !== want.wid)    report_mismatch("rect_width", rect_width, want.wid);
        if (rect_height !== want.hgt)   report_mismatch("rect_height", rect_height, want.hgt);
        if (colour !== want.colour)
          report_mismatch("colour", 16'(colour), 16'(want.colour));
        if (last_rect !== want.last)
          report_mismatch("last_rect", 16'(last_rect), 16'(want.last));
      end
      if (last_rect === 1'b1) begin
        if (typed_counts.size() != 0) begin
          typed = typed_counts.pop_front();
          if (typed != NO_COUNT && typed != rects_in_update)
            report_mismatch("rects per update", rects_in_update[15:0], typed[15:0]);
        end
        rects_in_update = 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) n_updates <= 0;
    else if (in_valid && !in_stall) n_updates <= n_updates + 1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold once the input side is busy.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_updates >= HOLD_AT) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 35);
      end
    end
  end

  initial begin
    logic [11:0] plan [7][4];
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic        tv;
    errors = 0;
    rects_seen = 0;
    rects_in_update = 0;
    calm = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    hour = '0;
    minute = '0;
    time_valid = 1'b0;
    nudge = '0;
    cfg_write = 1'b0;
    cfg_index = REG_SCREEN_X;
    cfg_data = '0;
    scr_x = 0;
    scr_y = 0;
    scr_w = 320;
    scr_h = 240;
    plan = '{
      '{12'd4095, 12'd4095, 12'd4095, 12'd4095},
      '{12'd0,    12'd0,    12'd0,    12'd0},
      '{12'd4095, 12'd0,    12'd1,    12'd4095},
      '{12'd0,    12'd4095, 12'd4095, 12'd1},
      '{12'd0,    12'd0,    12'd0,    12'd0},
      '{12'd0,    12'd0,    12'd0,    12'd0},
      '{12'd0,    12'd0,    12'd320,  12'd240}
    };
    plan[4] = '{12'($urandom_range(1000)), 12'($urandom_range(1000)),
                12'($urandom_range(800, 60)), 12'($urandom_range(600, 40))};
    plan[5] = '{12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom)};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    foreach (DIRECTED[i])
      send_update(DIRECTED[i].hr, DIRECTED[i].mn, DIRECTED[i].tv, DIRECTED[i].ng,
                  DIRECTED[i].count);

    for (int ph = 0; ph <= 7; ph++) begin
      if (ph > 0) begin
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        set_screen(plan[ph-1][0], plan[ph-1][1], plan[ph-1][2], plan[ph-1][3]);
      end
      calm <= (ph == 1);
      for (int k = 0; k < ((ph == 0) ? 40 : PHASE_ITEMS); k++) begin
        if (ph == 3 && k == 25) wait_drained();
        if ($urandom_range(99) < 85) begin
          hr = 5'($urandom_range(23));
          mn = 6'($urandom_range(59));
        end else begin
          hr = 5'($urandom);
          mn = 6'($urandom);
        end
        tv = ($urandom_range(99) < 80);
        send_update(hr, mn, tv, 16'($urandom), NO_COUNT);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
sv/sscrg_pkg.sv
sv/sscrg_front.sv
sv/sscrg_queue.sv
sv/sscrg_layout.sv
sv/sscrg_back.sv
sv/seven_segment_clock_rect_generator.sv
tb/tb_seven_segment_clock_rect_generator.sv
